// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pdm_pkg.sv =====
package pdm_pkg;

    localparam int ACC_W                = 37;
    localparam int MAG_W                = 36;
    localparam int CNT_W                = 5;
    localparam int SAMPLE_W             = 32;
    localparam int CFG_DATA_W           = 8;
    localparam int DIV_STEPS            = MAG_W;
    localparam int STEP_W               = $clog2(DIV_STEPS);
    localparam int MAX_CHANNELS_DEFAULT = 16;

    typedef enum logic [1:0] {
        DEPTH_8  = 2'd0,
        DEPTH_16 = 2'd1,
        DEPTH_24 = 2'd2,
        DEPTH_32 = 2'd3
    } depth_t;

    typedef enum logic {
        CFG_DEPTH    = 1'b0,
        CFG_CHANNELS = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic acc_add;
        logic div_step;
        logic out_load;
    } pdm_cmd_t;

    typedef struct packed {
        logic frame_end;
        logic div_last;
        logic out_free;
    } pdm_status_t;

endpackage

// ===== rtl/pcm_downmix_to_mono_core.sv =====
// A sample that does not end a frame is added to the accumulator when it is accepted.
// A frame-ending sample starts a 36-step bit-serial divider (one quotient bit
// per cycle); its result is then loaded into the output register once that is free.
// No new request is accepted during division or until the result is loaded.
// Reset: rst_n async low; depth 16 bit, 2 channels, empty frame, no result.
module pcm_downmix_to_mono_core
    import pdm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SAMPLE_W-1:0]   sample_word,
    input  logic                  last_in_buffer,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   mono_sample,
    output logic                  last_of_buffer,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pdm_cmd_t    cmd;
    pdm_status_t status;

    assign cfg_ready = 1'b1;

    pdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pdm_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index_t'(cfg_index)),
        .cfg_data       (cfg_data),
        .sample_word    (sample_word),
        .last_in_buffer (last_in_buffer),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .mono_sample    (mono_sample),
        .last_of_buffer (last_of_buffer)
    );

endmodule

// ===== rtl/pdm_ctrl.sv =====
module pdm_ctrl
    import pdm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  pdm_status_t status,
    output pdm_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        cmd.acc_add  = 1'b0;
        cmd.div_step = 1'b0;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.acc_add = accept;
                if (accept && status.frame_end)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/pdm_datapath.sv =====
module pdm_datapath
    import pdm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdm_cmd_t              cmd,
    output pdm_status_t           status,
    input  logic                  cfg_valid,
    input  cfg_index_t            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [SAMPLE_W-1:0]   sample_word,
    input  logic                  last_in_buffer,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SAMPLE_W-1:0]   mono_sample,
    output logic                  last_of_buffer
);

    localparam int CNT_MAX = (1 << CNT_W) - 1;
    localparam logic [CNT_W-1:0] MAX_EFF =
        (MAX_CHANNELS > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(MAX_CHANNELS);

    depth_t              depth_reg;
    logic [CNT_W-1:0]    chan_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [CNT_W-1:0]    pos_reg;
    logic                end_reg;
    logic [MAG_W-1:0]    q_reg;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    div_reg;
    logic                neg_reg;
    depth_t              mode_reg;
    logic                last_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] mono_reg;
    logic                flag_reg;

    logic [CNT_W-1:0]    n_eff;
    logic [ACC_W-1:0]    sample_ext;
    logic [ACC_W-1:0]    sum_next;
    logic [ACC_W-1:0]    sum_abs;
    logic [CNT_W:0]      pos_plus;
    logic [CNT_W:0]      trial;
    logic [CNT_W:0]      diff;
    logic                q_bit;
    logic [ACC_W-1:0]    q_signed;
    logic [SAMPLE_W-1:0] q_low;
    logic [SAMPLE_W-1:0] result;

    always_comb
    begin
        if (chan_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (chan_reg > MAX_EFF)
        begin
            n_eff = MAX_EFF;
        end
        else
        begin
            n_eff = chan_reg;
        end
    end

    always_comb
    begin
        case (depth_reg)
            DEPTH_8:  sample_ext = {{(ACC_W-8){sample_word[7]}}, sample_word[7:0]};
            DEPTH_16: sample_ext = {{(ACC_W-16){sample_word[15]}}, sample_word[15:0]};
            DEPTH_24: sample_ext = {{(ACC_W-32){sample_word[23]}}, sample_word[23:0], 8'b0};
            default:  sample_ext = {{(ACC_W-32){sample_word[31]}}, sample_word};
        endcase
    end

    assign sum_next = acc_reg + sample_ext;
    assign sum_abs  = sum_next[ACC_W-1] ? (ACC_W'(0) - sum_next) : sum_next;
    assign pos_plus = {1'b0, pos_reg} + (CNT_W+1)'(1);

    assign trial = {rem_reg, q_reg[MAG_W-1]};
    assign q_bit = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    assign q_signed = neg_reg ? (ACC_W'(0) - {1'b0, q_reg}) : {1'b0, q_reg};
    assign q_low    = q_signed[SAMPLE_W-1:0];
    assign result   = (mode_reg == DEPTH_24) ? {{8{q_low[31]}}, q_low[31:8]} : q_low;

    assign status.frame_end = (pos_plus >= {1'b0, n_eff});
    assign status.div_last  = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign mono_sample    = mono_reg;
    assign last_of_buffer = flag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= DEPTH_16;
            chan_reg      <= CNT_W'(2);
            acc_reg       <= '0;
            pos_reg       <= '0;
            end_reg       <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_DEPTH:    depth_reg <= depth_t'(cfg_data[1:0]);
                    CFG_CHANNELS: chan_reg  <= cfg_data[CNT_W-1:0];
                    default:      chan_reg  <= chan_reg;
                endcase
            end
            if (cmd.acc_add)
            begin
                if (status.frame_end)
                begin
                    acc_reg  <= '0;
                    pos_reg  <= '0;
                    end_reg  <= 1'b0;
                    step_reg <= '0;
                end
                else
                begin
                    acc_reg <= sum_next;
                    pos_reg <= pos_plus[CNT_W-1:0];
                    end_reg <= end_reg | last_in_buffer;
                end
            end
            if (cmd.div_step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_add && status.frame_end)
        begin
            q_reg    <= sum_abs[MAG_W-1:0];
            rem_reg  <= '0;
            div_reg  <= n_eff;
            neg_reg  <= sum_next[ACC_W-1];
            mode_reg <= depth_reg;
            last_reg <= end_reg | last_in_buffer;
        end
        else if (cmd.div_step)
        begin
            q_reg   <= {q_reg[MAG_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        end
        if (cmd.out_load)
        begin
            mono_reg <= result;
            flag_reg <= last_reg;
        end
    end

endmodule

// ===== rtl/pdm_checker.sv =====
`include "assert_macros.svh"

module pdm_checker
    import pdm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic [SAMPLE_W-1:0]   sample_word,
    input logic                  last_in_buffer,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [SAMPLE_W-1:0]   mono_sample,
    input logic                  last_of_buffer,
    input logic                  cfg_valid,
    input logic                  cfg_ready,
    input logic                  cfg_index,
    input logic [CFG_DATA_W-1:0] cfg_data
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mono_sample) && $stable(last_of_buffer), "result changed while stalled")
    `ASSERT_NEXT(a_no_instant_result, in_valid && in_ready, !$rose(out_valid), "result rose right after a request")
    `ASSERT_SAME(a_ready_on_result, $rose(out_valid), in_ready, "input not ready when result issued")
    `ASSERT_SAME(a_cfg_always_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind pcm_downmix_to_mono_core pdm_checker u_pdm_checker (.*);
